// ----- sv/multibyte_delimiter_splitter_core_macros.svh -----
// assertion macros for the delimiter splitter core
`ifndef MULTIBYTE_DELIMITER_SPLITTER_CORE_MACROS_SVH
`define MULTIBYTE_DELIMITER_SPLITTER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/mds_pkg.sv -----
// shared types and constants for the delimiter splitter
`timescale 1ns / 1ps

package mds_pkg;

    localparam int MAX_DELIM   = 8;
    localparam int HOLD_DEPTH  = MAX_DELIM - 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_DATA    = 2'd0;
    localparam logic [1:0] KIND_SECTION = 2'd1;
    localparam logic [1:0] KIND_STREAM  = 2'd2;

    localparam logic REG_DELIM_BYTES  = 1'b0;
    localparam logic REG_DELIM_LENGTH = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] out_kind;
        logic       last_result;
    } out_item_t;

    // one accepted item's work: released bytes, tail aligned (entry 0 newest)
    typedef struct packed {
        logic [MAX_DELIM-1:0][7:0] bytes;
        logic [3:0]                top;
        logic [3:0]                rel;
        logic [3:0]                total;
        logic [1:0]                marker_kind;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ----- sv/mds_front.sv -----
// front end: config registers, held tail, delimiter matching, command build
`timescale 1ns / 1ps

module mds_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  mds_pkg::in_item_t byte_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_data,
    input  mds_pkg::q_stat_t  q_stat,
    output logic              push,
    output mds_pkg::cmd_t     cmd
);
    import mds_pkg::*;

    logic [63:0] delim_reg;
    logic [3:0]  dlen_reg;
    logic [7:0]  hold_reg  [HOLD_DEPTH];
    logic [7:0]  hold_next [HOLD_DEPTH];
    logic [2:0]  hcnt_reg;
    logic [2:0]  hcnt_next;

    logic                      accept;
    logic [3:0]                len;
    logic [3:0]                m;
    logic [MAX_DELIM-1:0][7:0] t;
    logic [MAX_DELIM-1:0]      match;
    logic                      full;
    logic [2:0]                k;

    assign cfg_ready  = 1'b1;
    assign byte_stall = q_stat.full;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        if (dlen_reg == 4'd0)
            len = 4'd1;
        else if (dlen_reg > 4'(MAX_DELIM))
            len = 4'(MAX_DELIM);
        else
            len = dlen_reg;

        m = {1'b0, hcnt_reg} + 4'd1;

        // tail aligned window: newest byte first
        t[0] = byte_item.data_byte;
        for (int j = 1; j < MAX_DELIM; j++)
            t[j] = hold_reg[j-1];

        // match[l]: the last l+1 bytes equal the first l+1 delimiter bytes
        for (int l = 0; l < MAX_DELIM; l++)
        begin
            match[l] = (4'(l + 1) <= m);
            for (int i = 0; i <= l; i++)
                if (t[l-i] != delim_reg[8*i +: 8])
                    match[l] = 1'b0;
        end

        full = match[3'(len - 4'd1)];

        k = 3'd0;
        for (int l = 0; l < HOLD_DEPTH; l++)
            if (match[l] && (4'(l + 1) < len))
                k = 3'(l + 1);

        for (int j = 0; j < HOLD_DEPTH; j++)
            hold_next[j] = hold_reg[j];
        hcnt_next = hcnt_reg;

        cmd.marker_kind = KIND_DATA;
        if (byte_item.end_of_input)
        begin
            for (int j = 0; j < HOLD_DEPTH; j++)
                cmd.bytes[j] = hold_reg[j];
            cmd.bytes[MAX_DELIM-1] = 8'h00;
            cmd.top         = {1'b0, hcnt_reg};
            cmd.rel         = {1'b0, hcnt_reg};
            cmd.total       = {1'b0, hcnt_reg} + 4'd1;
            cmd.marker_kind = KIND_STREAM;
            hcnt_next       = 3'd0;
        end
        else if (full)
        begin
            cmd.bytes       = t;
            cmd.top         = m;
            cmd.rel         = m - len;
            cmd.total       = m - len + 4'd1;
            cmd.marker_kind = KIND_SECTION;
            hcnt_next       = 3'd0;
        end
        else
        begin
            cmd.bytes = t;
            cmd.top   = m;
            cmd.rel   = m - {1'b0, k};
            cmd.total = m - {1'b0, k};
            for (int j = 0; j < HOLD_DEPTH; j++)
                hold_next[j] = t[j];
            hcnt_next = k;
        end

        push = accept && (cmd.total != 4'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= 64'd0;
            dlen_reg  <= 4'd1;
            hcnt_reg  <= 3'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_DELIM_BYTES:  delim_reg <= cfg_data;
                    REG_DELIM_LENGTH: dlen_reg  <= cfg_data[3:0];
                    default:          ;
                endcase
            end
            if (accept)
                hcnt_reg <= hcnt_next;
        end
    end

    // held bytes are read only below the held count
    always_ff @(posedge clk)
    begin
        if (accept)
            for (int j = 0; j < HOLD_DEPTH; j++)
                hold_reg[j] <= hold_next[j];
    end

endmodule

// ----- sv/mds_queue.sv -----
// short command queue between front and back
`timescale 1ns / 1ps

module mds_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  mds_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output mds_pkg::cmd_t    head,
    output mds_pkg::q_stat_t q_stat
);
    import mds_pkg::*;

    cmd_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg,  count_next;

    assign head         = mem[rd_ptr_reg];
    assign q_stat.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign q_stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- sv/mds_back.sv -----
// back end: walks one command at a time and emits its results
`timescale 1ns / 1ps

module mds_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mds_pkg::cmd_t      head,
    input  mds_pkg::q_stat_t   q_stat,
    output logic               pop,
    output logic               busy,
    output logic               res_valid,
    input  logic               res_stall,
    output mds_pkg::out_item_t res_item
);
    import mds_pkg::*;

    cmd_t      cur_reg,       cur_next;
    logic      cur_valid_reg, cur_valid_next;
    logic [2:0] idx_reg,      idx_next;
    logic      res_valid_reg, res_valid_next;
    out_item_t res_item_reg,  res_item_next;

    logic      slot_free;
    logic      emit;
    logic      cur_last;
    out_item_t result;

    assign busy      = cur_valid_reg;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    always_comb
    begin
        slot_free = !res_valid_reg || !res_stall;
        emit      = slot_free && cur_valid_reg;
        cur_last  = ({1'b0, idx_reg} == cur_reg.total - 4'd1);
        pop       = !q_stat.empty && (!cur_valid_reg || (emit && cur_last));

        // released bytes go oldest first, the marker after them
        if ({1'b0, idx_reg} < cur_reg.rel)
        begin
            result.out_byte = cur_reg.bytes[3'(cur_reg.top - 4'd1 - {1'b0, idx_reg})];
            result.out_kind = KIND_DATA;
        end
        else
        begin
            result.out_byte = 8'h00;
            result.out_kind = cur_reg.marker_kind;
        end
        result.last_result = cur_last;

        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        idx_next       = idx_reg;
        if (pop)
        begin
            cur_next       = head;
            cur_valid_next = 1'b1;
            idx_next       = 3'd0;
        end
        else if (emit)
        begin
            if (cur_last)
                cur_valid_next = 1'b0;
            idx_next = idx_reg + 3'd1;
        end

        res_valid_next = slot_free ? cur_valid_reg : res_valid_reg;
        res_item_next  = emit ? result : res_item_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= 3'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        res_item_reg <= res_item_next;
    end

endmodule

// ----- sv/multibyte_delimiter_splitter_core.sv -----
// top level of the streaming multibyte delimiter splitter
//
//  channel | direction | handshake        | payload
//  byte    | in        | valid / stall    | data_byte, end_of_input
//  res     | out       | valid / stall    | out_byte, out_kind, last_result
//  cfg     | in        | valid / ready    | index (1 bit), data (64 bits)
//
// the front takes one item per cycle while the queue is not full and classifies it in that same cycle;
// the back emits one result per cycle unless res_stall holds it, and finishes all results of an item
// a four-entry command queue between them absorbs bursts such as an end-of-input flush
// results pass through the queue, the back's current command and its result register; held-back bytes cause no result
// reset clears the held count, queue and back control; cfg_ready is always high
`timescale 1ns / 1ps
`include "multibyte_delimiter_splitter_core_macros.svh"

module multibyte_delimiter_splitter_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_stall,
    input  mds_pkg::in_item_t  byte_item,
    output logic               res_valid,
    input  logic               res_stall,
    output mds_pkg::out_item_t res_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [63:0]        cfg_data
);
    import mds_pkg::*;

    logic    push;
    logic    pop;
    logic    back_busy;
    cmd_t    push_cmd;
    cmd_t    head;
    q_stat_t q_stat;

    logic    res_marker;
    logic    marker_clean;
    logic    eoi_accept;
    logic    work_pending;

    mds_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .q_stat     (q_stat),
        .push       (push),
        .cmd        (push_cmd)
    );

    mds_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    mds_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .busy      (back_busy),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    assign res_marker   = res_valid && (res_item.out_kind != KIND_DATA);
    assign marker_clean = (res_item.out_byte == 8'h00);
    assign eoi_accept   = byte_valid && !byte_stall && byte_item.end_of_input;
    assign work_pending = !q_stat.empty || back_busy || res_valid;

    `MDS_ASSERT_NOW(a_marker_zero_byte, res_marker, marker_clean, "marker with nonzero byte")
    `MDS_ASSERT_NOW(a_marker_is_last, res_marker, res_item.last_result, "marker not last")
    `MDS_ASSERT_NEXT(a_eoi_queued, eoi_accept, work_pending, "end of input left no work")

endmodule

// ----- verif/tb_multibyte_delimiter_splitter_core.sv -----
// self-checking testbench for the streaming multibyte delimiter splitter core
`timescale 1ns / 1ps

module tb_multibyte_delimiter_splitter_core;

    import mds_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    in_item_t    byte_item = '0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    out_item_t   res_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [63:0] cfg_data = '0;

    // splitter state as seen from outside, mirrors the block after reset
    logic [7:0]  held_buf [0:7];
    int          held_num = 0;
    logic [63:0] delim_word = '0;
    logic [3:0]  delim_len_field = 4'd1;

    out_item_t   split_results [$];
    out_item_t   next_result;
    int          bad_results = 0;
    int          cycle_count = 0;

    // receiver behavior and sender burst state
    int          rx_pct = 0;
    int          rx_hold_left = 0;
    logic [5:0]  rx_tick = '0;
    int          burst_left = 0;

    multibyte_delimiter_splitter_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int active_len();
        if (delim_len_field == 4'd0)
            return 1;
        if (delim_len_field > MAX_DELIM)
            return MAX_DELIM;
        return int'(delim_len_field);
    endfunction

    // works out the results of one accepted item and updates the held tail
    task automatic split_byte_item(input in_item_t it);
        logic [7:0] seq [0:8];
        logic [7:0] rb [0:8];
        logic [1:0] rk [0:8];
        out_item_t  r;
        int         cnt, n, m, len, k, i;
        bit         full, ok;
        cnt = 0;
        n = held_num;
        if (it.end_of_input)
        begin
            for (i = 0; i < n; i++)
            begin
                rb[cnt] = held_buf[i];
                rk[cnt] = KIND_DATA;
                cnt++;
            end
            rb[cnt] = 8'h00;
            rk[cnt] = KIND_STREAM;
            cnt++;
            held_num = 0;
        end
        else
        begin
            len = active_len();
            m = n + 1;
            for (i = 0; i < n; i++)
                seq[i] = held_buf[i];
            seq[n] = it.data_byte;
            full = (m >= len);
            for (i = 0; full && i < len; i++)
                if (seq[m - len + i] != delim_word[i*8 +: 8])
                    full = 1'b0;
            if (full)
            begin
                for (i = 0; i < m - len; i++)
                begin
                    rb[cnt] = seq[i];
                    rk[cnt] = KIND_DATA;
                    cnt++;
                end
                rb[cnt] = 8'h00;
                rk[cnt] = KIND_SECTION;
                cnt++;
                held_num = 0;
            end
            else
            begin
                // longest tail that still begins the delimiter
                k = (m < len - 1) ? m : len - 1;
                ok = 1'b0;
                while (k > 0 && !ok)
                begin
                    ok = 1'b1;
                    for (i = 0; i < k; i++)
                        if (seq[m - k + i] != delim_word[i*8 +: 8])
                            ok = 1'b0;
                    if (!ok)
                        k--;
                end
                for (i = 0; i < m - k; i++)
                begin
                    rb[cnt] = seq[i];
                    rk[cnt] = KIND_DATA;
                    cnt++;
                end
                for (i = 0; i < k; i++)
                    held_buf[i] = seq[m - k + i];
                held_num = k;
            end
        end
        for (i = 0; i < cnt; i++)
        begin
            r.out_byte = rb[i];
            r.out_kind = rk[i];
            r.last_result = (i == cnt - 1);
            split_results.push_back(r);
        end
    endtask

    // predicts on accepted items and register writes, checks accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_DELIM_BYTES)
                    delim_word = cfg_data;
                else
                    delim_len_field = cfg_data[3:0];
            end
            if (byte_valid && !byte_stall)
                split_byte_item(byte_item);
            if (res_valid && !res_stall)
            begin
                if (split_results.size() == 0)
                begin
                    $display("%0t: unexpected result, actual byte %h kind %0d last %0b",
                             $time, res_item.out_byte, res_item.out_kind,
                             res_item.last_result);
                    bad_results++;
                end
                else
                begin
                    next_result = split_results.pop_front();
                    if (res_item.out_byte !== next_result.out_byte)
                    begin
                        $display("%0t: out_byte expected %h actual %h",
                                 $time, next_result.out_byte, res_item.out_byte);
                        bad_results++;
                    end
                    if (res_item.out_kind !== next_result.out_kind)
                    begin
                        $display("%0t: out_kind expected %0d actual %0d",
                                 $time, next_result.out_kind, res_item.out_kind);
                        bad_results++;
                    end
                    if (res_item.last_result !== next_result.last_result)
                    begin
                        $display("%0t: last_result expected %0b actual %0b",
                                 $time, next_result.last_result, res_item.last_result);
                        bad_results++;
                    end
                end
            end
        end
    end

    // receiver: stall in holds, else quiet while rx_tick[5] low, random if high
    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 6'd1;
        if (rx_hold_left > 0)
        begin
            res_stall <= 1'b1;
            rx_hold_left = rx_hold_left - 1;
        end
        else if (rx_tick[5] && $urandom_range(0, 99) < rx_pct)
            res_stall <= 1'b1;
        else
            res_stall <= 1'b0;
    end

    task automatic send_byte(input in_item_t it);
        byte_valid <= 1'b1;
        byte_item <= it;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
    endtask

    task automatic push_byte(input logic eoi, input logic [7:0] b);
        in_item_t it;
        it.end_of_input = eoi;
        it.data_byte = b;
        send_byte(it);
    endtask

    task automatic offer_item(input in_item_t it, input int gap_max);
        int gap;
        if (burst_left == 0)
        begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        send_byte(it);
    endtask

    // sender pauses until every predicted result is out, then lets the pipe settle
    task automatic drain_results();
        byte_valid <= 1'b0;
        // let the predictor see the last accepted item first
        @(posedge clk);
        while (split_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // upper bits of the length write are junk, only bits 3:0 count
    task automatic set_delimiter(input logic [63:0] word, input logic [3:0] len);
        write_reg(REG_DELIM_BYTES, word);
        write_reg(REG_DELIM_LENGTH, {$urandom, 28'($urandom), len});
    endtask

    // mostly whole delimiters and delimiter bytes, some broken ones, noise and end-of-input items
    task automatic run_stream(input int n_items, input int gap_max);
        in_item_t it;
        int       sent, len, i, pick, bad_at;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            len = active_len();
            if (pick < 25)
            begin
                bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : len;
                for (i = 0; i < len; i++)
                begin
                    it.end_of_input = 1'b0;
                    it.data_byte = (i == bad_at) ? 8'($urandom_range(0, 255))
                                                 : delim_word[i*8 +: 8];
                    offer_item(it, gap_max);
                end
                sent += len;
            end
            else
            begin
                it.end_of_input = (pick < 31);
                if (pick < 60)
                    it.data_byte = delim_word[$urandom_range(0, len - 1)*8 +: 8];
                else
                    it.data_byte = 8'($urandom_range(0, 255));
                offer_item(it, gap_max);
                sent++;
            end
        end
    endtask

    task automatic test_default_delimiter();
        rx_pct = 25;
        push_byte(1'b0, 8'h00);
        push_byte(1'b0, 8'hff);
        push_byte(1'b1, 8'h00);
        push_byte(1'b1, 8'hff);
        push_byte(1'b0, 8'h00);
        drain_results();
    endtask

    // overlapping prefixes: ABABABAB falls back to ABABAB, then ABABABAC matches
    task automatic test_straddling_delimiter();
        logic [7:0] pattern [0:9];
        int         i;
        pattern = '{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h43};
        set_delimiter(64'h4341_4241_4241_4241, 4'd8);
        for (i = 0; i < 10; i++)
            push_byte(1'b0, pattern[i]);
        push_byte(1'b0, 8'h41);
        push_byte(1'b1, 8'h00);
        drain_results();
    endtask

    // held bytes survive a length change and are matched at the tail only
    task automatic test_reconfig_mid_stream();
        push_byte(1'b0, 8'h41);
        push_byte(1'b0, 8'h42);
        write_reg(REG_DELIM_LENGTH, 64'd0);
        push_byte(1'b0, 8'h41);
        push_byte(1'b1, 8'h00);
        drain_results();
    endtask

    task automatic test_random_mix();
        logic [63:0] word;
        int          i;
        set_delimiter({$urandom, $urandom}, 4'($urandom_range(2, 7)));
        rx_pct = 30;
        run_stream(55, 4);

        // small alphabet so partial matches keep recurring
        for (i = 0; i < 8; i++)
            word[i*8 +: 8] = ($urandom_range(0, 2) != 0) ? 8'ha5 : 8'($urandom_range(0, 255));
        set_delimiter(word, 4'd8);
        rx_pct = 50;
        run_stream(55, 2);

        // no idling on either side
        set_delimiter('1, 4'd15);
        rx_pct = 0;
        run_stream(45, 0);

        set_delimiter({$urandom, $urandom}, 4'd0);
        rx_pct = 60;
        run_stream(50, 6);

        set_delimiter(64'd0, 4'd3);
        rx_pct = 20;
        run_stream(45, 3);
        drain_results();
    endtask

    // receiver holds off long enough for the block to stall its input
    task automatic test_backpressure();
        set_delimiter({$urandom, $urandom}, 4'd2);
        rx_pct = 0;
        @(negedge clk);
        rx_hold_left = 150;
        @(posedge clk);
        run_stream(40, 0);
        drain_results();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_delimiter();
        test_straddling_delimiter();
        test_reconfig_mid_stream();
        test_random_mix();
        test_backpressure();
        drain_results();
        if (bad_results == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
